// ----- rtl/core/ordered_list_store_defines.svh -----
// Assertion macros shared by the ordered list store checkers.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ORDERED_LIST_STORE_DEFINES_SVH
`define ORDERED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OLS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ols_pkg.sv -----
// Types and codes for the ordered list store.
// No dependencies; used by every module of the block.
package ols_pkg;

	localparam int CODE_W    = 16;
	localparam int WEIGHT_W  = 32;
	localparam int REQ_W     = 4;
	localparam int POS_W     = 8;
	localparam int STATUS_W  = 3;
	localparam int CNT_OUT_W = 7;

	typedef struct packed {
		logic [CODE_W-1:0]   code;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_POS   = 4'd0,
		REQ_INS_FRONT = 4'd1,
		REQ_INS_END   = 4'd2,
		REQ_RM_POS    = 4'd3,
		REQ_RM_FRONT  = 4'd4,
		REQ_RM_END    = 4'd5,
		REQ_RM_CODE   = 4'd6,
		REQ_READ      = 4'd7,
		REQ_FIND      = 4'd8,
		REQ_CLEAR     = 4'd9
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_BADPOS = 3'd3,
		ST_NOCODE = 3'd4
	} status_t;

endpackage

// ----- rtl/core/ordered_list_store.sv -----
// Top level of the ordered list store: sequencer plus entry memory.
// Depends on ols_pkg, ols_ctrl and ols_mem.
//
// A request word (req_type, position, key_code, weight_word) is taken at a rising
// edge where start is high and busy is low. Exactly one result word comes back:
// done is high for one cycle while status, out_code, out_weight, found_position,
// entry_count, is_full and is_empty are valid. The receiver cannot hold it off.
// Requests that need no memory access (full, empty or bad position, clear and
// unused codes) return done in the cycle right after acceptance.
// Every other request runs through the entry memory, one entry per cycle.
// An insert moves the entries from its position on up by one place and then
// writes the new entry there; a remove reads its entry and moves the entries
// behind it down by one place; a read fetches one entry; a find reads from the
// front until the code hits or the list ends; a remove by code does the same
// and then moves the entries behind the hit down.
// busy stays high while a request is in flight; no new request is taken then.
// The next request can be taken at the edge that ends the done cycle.
// Reset empties the list; memory contents are not cleared and are never read
// before being written.
module ordered_list_store #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ols_pkg::REQ_W-1:0]      req_type,
	input  logic [ols_pkg::POS_W-1:0]      position,
	input  logic [ols_pkg::CODE_W-1:0]     key_code,
	input  logic [ols_pkg::WEIGHT_W-1:0]   weight_word,
	output logic                           done,
	output logic [ols_pkg::STATUS_W-1:0]   status,
	output logic [ols_pkg::CODE_W-1:0]     out_code,
	output logic [ols_pkg::WEIGHT_W-1:0]   out_weight,
	output logic [ols_pkg::CNT_OUT_W-1:0]  found_position,
	output logic [ols_pkg::CNT_OUT_W-1:0]  entry_count,
	output logic                           is_full,
	output logic                           is_empty
);
	import ols_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_wdata;
	entry_t        mem_rdata;

	ols_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.position       (position),
		.key_code       (key_code),
		.weight_word    (weight_word),
		.done           (done),
		.status         (status),
		.out_code       (out_code),
		.out_weight     (out_weight),
		.found_position (found_position),
		.entry_count    (entry_count),
		.is_full        (is_full),
		.is_empty       (is_empty),
		.mem_ctl        (mem_ctl),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

	ols_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ----- rtl/core/ols_mem.sv -----
// Entry storage of the ordered list store: one write and one read port.
// Depends on ols_pkg for the entry word type.
module ols_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  ols_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]    waddr,
	input  ols_pkg::entry_t  wdata,
	input  logic [AW-1:0]    raddr,
	output ols_pkg::entry_t  rdata
);
	import ols_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/ols_ctrl.sv -----
// Request decoder and sequencer of the ordered list store.
// Walks and shifts the entry memory one word per cycle; depends on ols_pkg.
module ols_ctrl #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ols_pkg::REQ_W-1:0]          req_type,
	input  logic [ols_pkg::POS_W-1:0]          position,
	input  logic [ols_pkg::CODE_W-1:0]         key_code,
	input  logic [ols_pkg::WEIGHT_W-1:0]       weight_word,
	output logic                               done,
	output logic [ols_pkg::STATUS_W-1:0]       status,
	output logic [ols_pkg::CODE_W-1:0]         out_code,
	output logic [ols_pkg::WEIGHT_W-1:0]       out_weight,
	output logic [ols_pkg::CNT_OUT_W-1:0]      found_position,
	output logic [ols_pkg::CNT_OUT_W-1:0]      entry_count,
	output logic                               is_full,
	output logic                               is_empty,
	output ols_pkg::mem_ctl_t                  mem_ctl,
	output logic [AW-1:0]                      mem_waddr,
	output ols_pkg::entry_t                    mem_wdata,
	output logic [AW-1:0]                      mem_raddr,
	input  ols_pkg::entry_t                    mem_rdata
);
	import ols_pkg::*;

	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int XW = CW + CNT_OUT_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_SHIFT = 3'b100
	} state_t;

	state_t                state_q;
	req_type_t             op_q;
	logic [CODE_W-1:0]     code_q;
	logic [WEIGHT_W-1:0]   weight_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         src_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         pidx_q;
	logic [AW-1:0]         pdst_q;
	logic                  inc_q;
	logic                  cap_q;
	logic                  pend_q;
	logic                  pcap_q;
	entry_t                went_q;
	logic                  done_q;

	logic                  acc;
	logic [PW-1:0]         pos_x;
	logic [PW-1:0]         cnt_x;
	logic                  pos_ok;
	logic [CW-1:0]         pos_m1;
	logic [CW-1:0]         cnt_m1;
	logic                  full_now;
	state_t                d_next;
	status_t               d_status;
	logic [CW-1:0]         d_idx;
	logic [CW-1:0]         d_src;
	logic [CW-1:0]         d_rem;
	logic                  d_inc;
	logic                  d_cap;
	logic [CW-1:0]         d_cnt;

	logic                  in_scan;
	logic                  in_shift;
	logic                  hit;
	logic                  miss;
	logic                  issue;
	logic                  shift_done;
	logic                  op_ins;
	logic [CW-1:0]         src_step;
	logic [CW-1:0]         dst;
	logic [CW-1:0]         pidx_p1;
	logic                  fin;
	status_t               fin_status;
	logic [CW-1:0]         fin_cnt;
	logic [CW-1:0]         fin_fpos;
	entry_t                fin_ent;
	logic [XW-1:0]         fin_cnt_x;
	logic [XW-1:0]         fin_fpos_x;

	always_comb begin
		acc      = start && (state_q == ST_IDLE);
		pos_x    = PW'(position);
		cnt_x    = PW'(cnt_q);
		pos_ok   = (position != '0) && (pos_x <= cnt_x);
		pos_m1   = CW'(pos_x - PW'(1));
		cnt_m1   = cnt_q - CW'(1);
		full_now = (cnt_q == CW'(DEPTH));
		d_next   = ST_IDLE;
		d_status = ST_OK;
		d_idx    = '0;
		d_src    = '0;
		d_rem    = '0;
		d_inc    = 1'b1;
		d_cap    = 1'b0;
		d_cnt    = cnt_q;
		case (req_type_t'(req_type))
			REQ_INS_POS, REQ_INS_FRONT, REQ_INS_END: begin
				if (full_now) begin
					d_status = ST_FULL;
				end else if ((req_type_t'(req_type) == REQ_INS_POS) && !pos_ok) begin
					d_status = ST_BADPOS;
				end else begin
					if (req_type_t'(req_type) == REQ_INS_POS) begin
						d_idx = pos_m1;
					end else if (req_type_t'(req_type) == REQ_INS_FRONT) begin
						d_idx = '0;
					end else begin
						d_idx = cnt_q;
					end
					d_next = ST_SHIFT;
					d_src  = cnt_m1;
					d_rem  = cnt_q - d_idx;
					d_inc  = 1'b0;
				end
			end
			REQ_RM_POS, REQ_RM_FRONT, REQ_RM_END: begin
				if ((req_type_t'(req_type) == REQ_RM_POS) && !pos_ok) begin
					d_status = ST_BADPOS;
				end else if (cnt_q == '0) begin
					d_status = ST_EMPTY;
				end else begin
					if (req_type_t'(req_type) == REQ_RM_POS) begin
						d_idx = pos_m1;
					end else if (req_type_t'(req_type) == REQ_RM_FRONT) begin
						d_idx = '0;
					end else begin
						d_idx = cnt_m1;
					end
					d_next = ST_SHIFT;
					d_src  = d_idx;
					d_rem  = cnt_q - d_idx;
					d_cap  = 1'b1;
				end
			end
			REQ_RM_CODE: begin
				if (cnt_q == '0) begin
					d_status = ST_EMPTY;
				end else begin
					d_next = ST_SCAN;
					d_rem  = cnt_q;
				end
			end
			REQ_READ: begin
				if (!pos_ok) begin
					d_status = ST_BADPOS;
				end else begin
					d_next = ST_SHIFT;
					d_src  = pos_m1;
					d_rem  = CW'(1);
					d_cap  = 1'b1;
				end
			end
			REQ_FIND: begin
				d_next = ST_SCAN;
				d_rem  = cnt_q;
			end
			REQ_CLEAR: begin
				d_cnt = '0;
			end
			default: begin
				d_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		in_scan    = (state_q == ST_SCAN);
		in_shift   = (state_q == ST_SHIFT);
		hit        = in_scan && pend_q && (mem_rdata.code == code_q);
		miss       = in_scan && !pend_q && (rem_q == '0);
		issue      = (in_scan || in_shift) && (rem_q != '0) && !hit;
		shift_done = in_shift && (rem_q == '0) && !pend_q;
		op_ins     = (op_q == REQ_INS_POS) || (op_q == REQ_INS_FRONT) ||
			(op_q == REQ_INS_END);
		src_step   = inc_q ? (src_q + CW'(1)) : (src_q - CW'(1));
		dst        = inc_q ? (src_q - CW'(1)) : (src_q + CW'(1));
		pidx_p1    = pidx_q + CW'(1);

		mem_ctl    = '0;
		mem_ctl.re = issue;
		mem_raddr  = src_q[AW-1:0];
		mem_waddr  = pdst_q;
		mem_wdata  = mem_rdata;
		if (in_shift && pend_q && !pcap_q) begin
			mem_ctl.we = 1'b1;
		end
		if (shift_done && op_ins) begin
			mem_ctl.we = 1'b1;
			mem_waddr  = idx_q[AW-1:0];
			mem_wdata  = '{code: code_q, weight: weight_q};
		end

		fin        = 1'b0;
		fin_status = ST_OK;
		fin_cnt    = cnt_q;
		fin_fpos   = '0;
		fin_ent    = '0;
		if (acc && (d_next == ST_IDLE)) begin
			fin        = 1'b1;
			fin_status = d_status;
			fin_cnt    = d_cnt;
		end else if (hit && (op_q == REQ_FIND)) begin
			fin      = 1'b1;
			fin_fpos = pidx_p1;
			fin_ent  = mem_rdata;
		end else if (miss) begin
			fin        = 1'b1;
			fin_status = ST_NOCODE;
		end else if (shift_done) begin
			fin = 1'b1;
			if (op_ins) begin
				fin_cnt = cnt_q + CW'(1);
			end else begin
				fin_ent = went_q;
				if (op_q != REQ_READ) begin
					fin_cnt = cnt_q - CW'(1);
				end
			end
		end
		fin_cnt_x  = XW'(fin_cnt);
		fin_fpos_x = XW'(fin_fpos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			src_q   <= '0;
			rem_q   <= '0;
			inc_q   <= 1'b1;
			cap_q   <= 1'b0;
			pend_q  <= 1'b0;
			pcap_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			if (fin) begin
				cnt_q <= fin_cnt;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= d_next;
						src_q   <= d_src;
						rem_q   <= d_rem;
						inc_q   <= d_inc;
						cap_q   <= d_cap;
						pend_q  <= 1'b0;
						pcap_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						src_q <= src_step;
						rem_q <= rem_q - CW'(1);
					end
					if (hit) begin
						if (op_q == REQ_FIND) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SHIFT;
							src_q   <= pidx_p1;
							rem_q   <= cnt_q - pidx_p1;
							inc_q   <= 1'b1;
							cap_q   <= 1'b0;
						end
					end else if (miss) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SHIFT: begin
					pend_q <= issue;
					pcap_q <= cap_q && issue;
					if (issue) begin
						src_q <= src_step;
						rem_q <= rem_q - CW'(1);
						cap_q <= 1'b0;
					end
					if (shift_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= req_type_t'(req_type);
			code_q   <= key_code;
			weight_q <= weight_word;
			idx_q    <= d_idx;
		end
		if (in_scan) begin
			pidx_q <= src_q;
		end
		pdst_q <= dst[AW-1:0];
		if (hit || (in_shift && pend_q && pcap_q)) begin
			went_q <= mem_rdata;
		end
		if (fin) begin
			status         <= fin_status;
			out_code       <= fin_ent.code;
			out_weight     <= fin_ent.weight;
			found_position <= fin_fpos_x[CNT_OUT_W-1:0];
			entry_count    <= fin_cnt_x[CNT_OUT_W-1:0];
			is_full        <= (fin_cnt == CW'(DEPTH));
			is_empty       <= (fin_cnt == '0);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ----- rtl/core/ols_chk.sv -----
// Port-level checker for the ordered list store, bound to the top level.
// Depends on ols_pkg and ordered_list_store_defines.svh.
`include "ordered_list_store_defines.svh"

module ols_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [ols_pkg::STATUS_W-1:0]   status,
	input logic [ols_pkg::CNT_OUT_W-1:0]  entry_count,
	input logic                           is_full,
	input logic                           is_empty
);
	import ols_pkg::*;

	// An accepted request either keeps the block busy or answers at once.
	`OLS_ASSERT_NXT(a_accept_progress, start && !busy, busy || done, "request lost after accept")
	// A result word is only shown once the sequencer has gone idle.
	`OLS_ASSERT_IMP(a_done_not_busy, done, !busy, "result shown while busy")
	`OLS_ASSERT_IMP(a_empty_flag, done, is_empty == (entry_count == '0), "empty flag mismatch")
	`OLS_ASSERT_IMP(a_full_status, done && (status == ST_FULL), is_full, "full status on non-full list")
	`OLS_ASSERT_IMP(a_empty_status, done && (status == ST_EMPTY), is_empty, "empty status on non-empty list")

endmodule

bind ordered_list_store ols_chk u_ols_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.entry_count (entry_count),
	.is_full     (is_full),
	.is_empty    (is_empty)
);

// ----- verif/ordered_list_store_checker.sv -----
// Checker for the ordered list store: keeps its own copy of the list, predicts one reply
// word per accepted request and compares each reply word field by field.
// Depends on ols_pkg only; instantiated beside the block by ordered_list_store_tb.
module ordered_list_store_checker
	import ols_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [POS_W-1:0]      position,
	input  logic [CODE_W-1:0]     key_code,
	input  logic [WEIGHT_W-1:0]   weight_word,
	input  logic                  done,
	input  logic [STATUS_W-1:0]   status,
	input  logic [CODE_W-1:0]     out_code,
	input  logic [WEIGHT_W-1:0]   out_weight,
	input  logic [CNT_OUT_W-1:0]  found_position,
	input  logic [CNT_OUT_W-1:0]  entry_count,
	input  logic                  is_full,
	input  logic                  is_empty,
	output int                    fail_count,
	output int                    pending,
	output int                    list_len,
	output int                    checked,
	output int                    full_rejects
);

	typedef struct {
		status_t              st;
		logic [CODE_W-1:0]    code;
		logic [WEIGHT_W-1:0]  weight;
		logic [CNT_OUT_W-1:0] fpos;
		logic [CNT_OUT_W-1:0] cnt;
		logic                 full;
		logic                 empty;
	} list_reply_t;

	entry_t      slots [DEPTH];
	int          slot_count;
	list_reply_t replies_due [$];

	function automatic int locate_code(input logic [CODE_W-1:0] key);
		for (int k = 0; k < slot_count; k++) begin
			if (slots[k].code == key)
				return k;
		end
		return slot_count;
	endfunction

	function automatic list_reply_t apply_request(input logic [REQ_W-1:0] rt,
			input logic [POS_W-1:0] pos, input logic [CODE_W-1:0] key,
			input logic [WEIGHT_W-1:0] wt);
		list_reply_t r;
		int          idx;
		bit          pos_ok;
		r.st = ST_OK;
		r.code = '0;
		r.weight = '0;
		r.fpos = '0;
		pos_ok = (pos >= 1) && (pos <= slot_count);
		idx = slot_count;
		case (rt)
			REQ_INS_POS, REQ_INS_FRONT, REQ_INS_END: begin
				if (slot_count >= DEPTH) begin
					r.st = ST_FULL;
				end else if (rt == REQ_INS_POS && !pos_ok) begin
					r.st = ST_BADPOS;
				end else begin
					idx = (rt == REQ_INS_POS) ? pos - 1 : (rt == REQ_INS_FRONT) ? 0 : slot_count;
					for (int k = slot_count; k > idx; k--)
						slots[k] = slots[k - 1];
					slots[idx].code = key;
					slots[idx].weight = wt;
					slot_count++;
				end
			end
			REQ_RM_POS, REQ_RM_FRONT, REQ_RM_END, REQ_RM_CODE: begin
				if (rt == REQ_RM_POS && !pos_ok) begin
					r.st = ST_BADPOS;
				end else if (slot_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					case (rt)
						REQ_RM_POS:   idx = pos - 1;
						REQ_RM_FRONT: idx = 0;
						REQ_RM_END:   idx = slot_count - 1;
						default:      idx = locate_code(key);
					endcase
					if (idx >= slot_count) begin
						r.st = ST_NOCODE;
					end else begin
						r.code = slots[idx].code;
						r.weight = slots[idx].weight;
						for (int k = idx; k + 1 < slot_count; k++)
							slots[k] = slots[k + 1];
						slot_count--;
					end
				end
			end
			REQ_READ: begin
				if (!pos_ok) begin
					r.st = ST_BADPOS;
				end else begin
					r.code = slots[pos - 1].code;
					r.weight = slots[pos - 1].weight;
				end
			end
			REQ_FIND: begin
				idx = locate_code(key);
				if (idx >= slot_count) begin
					r.st = ST_NOCODE;
				end else begin
					r.code = slots[idx].code;
					r.weight = slots[idx].weight;
					r.fpos = CNT_OUT_W'(idx + 1);
				end
			end
			REQ_CLEAR: slot_count = 0;
			default: ;
		endcase
		r.cnt = CNT_OUT_W'(slot_count);
		r.full = (slot_count >= DEPTH);
		r.empty = (slot_count == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		list_reply_t want;
		list_reply_t fresh;
		if (!arst_n) begin
			slot_count = 0;
			replies_due.delete();
			fail_count = 0;
			checked = 0;
			full_rejects = 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: reply word with no request outstanding", $time);
				end else begin
					want = replies_due.pop_front();
					checked++;
					if (status !== want.st || out_code !== want.code ||
							out_weight !== want.weight || found_position !== want.fpos ||
							entry_count !== want.cnt || is_full !== want.full ||
							is_empty !== want.empty) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: reply mismatch, expected st=%0d code=%h wt=%h fpos=%0d cnt=%0d full=%b empty=%b",
								$time, want.st, want.code, want.weight, want.fpos, want.cnt,
								want.full, want.empty);
							$display("%0t: reply mismatch, got      st=%0d code=%h wt=%h fpos=%0d cnt=%0d full=%b empty=%b",
								$time, status, out_code, out_weight, found_position, entry_count,
								is_full, is_empty);
						end
					end
				end
			end
			if (start && !busy) begin
				fresh = apply_request(req_type, position, key_code, weight_word);
				if (fresh.st == ST_FULL)
					full_rejects++;
				replies_due.push_back(fresh);
			end
		end
		pending = replies_due.size();
		list_len = slot_count;
	end

endmodule

// ----- verif/ordered_list_store_tb.sv -----
// Top of the ordered list store testbench: clock, reset, directed and random request words.
// Depends on ols_pkg, ordered_list_store and ordered_list_store_checker.
module ordered_list_store_tb;
	import ols_pkg::*;

	localparam int DEPTH         = 64;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int CALM_TAIL     = 200;
	localparam int SETTLE_CYCLES = 150;
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = REQ_W'(REQ_CLEAR + 1);
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = '1;

	typedef enum {FILL, DRAIN, MIXED} drift_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [REQ_W-1:0]     req_type;
	logic [POS_W-1:0]     position;
	logic [CODE_W-1:0]    key_code;
	logic [WEIGHT_W-1:0]  weight_word;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [CODE_W-1:0]    out_code;
	logic [WEIGHT_W-1:0]  out_weight;
	logic [CNT_OUT_W-1:0] found_position;
	logic [CNT_OUT_W-1:0] entry_count;
	logic                 is_full;
	logic                 is_empty;
	int                   fail_count;
	int                   pending;
	int                   list_len;
	int                   checked;
	int                   full_rejects;
	int                   sent;

	ordered_list_store #(.DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .position(position), .key_code(key_code),
		.weight_word(weight_word), .done(done), .status(status), .out_code(out_code),
		.out_weight(out_weight), .found_position(found_position),
		.entry_count(entry_count), .is_full(is_full), .is_empty(is_empty)
	);

	ordered_list_store_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .position(position), .key_code(key_code),
		.weight_word(weight_word), .done(done), .status(status), .out_code(out_code),
		.out_weight(out_weight), .found_position(found_position),
		.entry_count(entry_count), .is_full(is_full), .is_empty(is_empty),
		.fail_count(fail_count), .pending(pending), .list_len(list_len),
		.checked(checked), .full_rejects(full_rejects)
	);

	always #6 clk = ~clk;

	initial begin
		#25_000_000;
		$display("[ordered_list_store] ERROR");
		$finish;
	end

	// Called at a falling edge; returns at the rising edge that takes the word.
	task automatic put_request(input logic [REQ_W-1:0] rt, input logic [POS_W-1:0] pos,
			input logic [CODE_W-1:0] key, input logic [WEIGHT_W-1:0] wt);
		start <= 1'b1;
		req_type <= rt;
		position <= pos;
		key_code <= key;
		weight_word <= wt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_fixed(input logic [REQ_W-1:0] rt, input logic [POS_W-1:0] pos,
			input logic [CODE_W-1:0] key, input logic [WEIGHT_W-1:0] wt);
		@(negedge clk);
		put_request(rt, pos, key, wt);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	task automatic drain_out();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_position(input int len);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return POS_W'($urandom_range(0, 255));
		if (r < 9)
			return '0;
		if (r < 13)
			return POS_W'(len + 1);
		if (len == 0)
			return POS_W'(1);
		if (r < 20)
			return POS_W'(len);
		if (r < 25)
			return POS_W'(1);
		return POS_W'($urandom_range(1, len));
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return CODE_W'($urandom_range(0, 11));
		if (r < 80)
			return $urandom_range(0, 1) ? '1 : '0;
		return CODE_W'($urandom);
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '1;
		if (r < 10)
			return '0;
		return $urandom;
	endfunction

	initial begin : stimulus
		drift_t           mode;
		int               directed;
		int               idle_pct;
		int               len;
		int               ins_pct;
		int               r;
		int               s;
		logic [REQ_W-1:0] rt;
		logic [POS_W-1:0] pos;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		position = '0;
		key_code = '0;
		weight_word = '0;
		sent = 0;
		mode = FILL;
		idle_pct = 0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_fixed(REQ_RM_FRONT, 8'd0, 16'h0000, 32'h0);
		send_fixed(REQ_RM_END, 8'd0, 16'h0000, 32'h0);
		send_fixed(REQ_RM_CODE, 8'd0, 16'h0007, 32'h0);
		send_fixed(REQ_FIND, 8'd0, 16'h0007, 32'h0);
		send_fixed(REQ_READ, 8'd1, 16'h0000, 32'h0);
		send_fixed(REQ_RM_POS, 8'd0, 16'h0000, 32'h0);
		send_fixed(REQ_INS_POS, 8'd1, 16'h0001, 32'h1);
		send_fixed(REQ_INS_END, 8'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_fixed(REQ_INS_FRONT, 8'd0, 16'h0000, 32'h0000_0000);
		send_fixed(REQ_INS_POS, 8'd1, 16'h1234, 32'h5678_9ABC);
		send_fixed(REQ_INS_POS, 8'd3, 16'hAAAA, 32'hAAAA_AAAA);
		send_fixed(REQ_INS_POS, 8'd0, 16'h5555, 32'h5555_5555);
		send_fixed(REQ_INS_POS, 8'd255, 16'h5555, 32'h5555_5555);
		send_fixed(REQ_READ, 8'd4, 16'h0000, 32'h0);
		send_fixed(REQ_READ, 8'd5, 16'h0000, 32'h0);
		send_fixed(REQ_FIND, 8'd0, 16'hFFFF, 32'h0);
		send_fixed(REQ_FIND, 8'd0, 16'h5555, 32'h0);
		send_fixed(REQ_RM_CODE, 8'd0, 16'h0000, 32'h0);
		send_fixed(REQ_RM_CODE, 8'd0, 16'h5555, 32'h0);
		send_fixed(REQ_RM_POS, 8'd2, 16'h0000, 32'h0);
		send_fixed(REQ_RM_POS, 8'd200, 16'h0000, 32'h0);
		send_fixed(REQ_SPARE_HI, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_fixed(REQ_RM_FRONT, 8'd0, 16'h0000, 32'h0);
		send_fixed(REQ_RM_END, 8'd0, 16'h0000, 32'h0);
		send_fixed(REQ_CLEAR, 8'd0, 16'h0000, 32'h0);
		directed = sent;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				r = $urandom_range(0, 2);
				idle_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
			end
			if (i % 400 == 399 && i < RANDOM_ITEMS - CALM_TAIL)
				drain_out();
			else if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 99) < idle_pct)
				hold_off($urandom_range(1, 18));
			@(negedge clk);
			len = list_len;
			case (mode)
				FILL:
					if (len == DEPTH && $urandom_range(0, 3) == 0)
						mode = $urandom_range(0, 1) ? DRAIN : MIXED;
				DRAIN:
					if (len == 0 && $urandom_range(0, 3) == 0)
						mode = FILL;
				default:
					if ($urandom_range(0, 59) == 0)
						mode = $urandom_range(0, 1) ? FILL : DRAIN;
			endcase
			ins_pct = (mode == FILL) ? 80 : (mode == DRAIN) ? 15 : 45;
			r = $urandom_range(0, 99);
			if (r < ins_pct) begin
				rt = REQ_W'($urandom_range(REQ_INS_POS, REQ_INS_END));
			end else begin
				s = $urandom_range(0, 99);
				if (s < 18)
					rt = REQ_RM_POS;
				else if (s < 28)
					rt = REQ_RM_FRONT;
				else if (s < 38)
					rt = REQ_RM_END;
				else if (s < 53)
					rt = REQ_RM_CODE;
				else if (s < 73)
					rt = REQ_READ;
				else if (s < 95 || mode == FILL)
					rt = REQ_FIND;
				else if (s < 98)
					rt = REQ_CLEAR;
				else
					rt = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
			end
			if (rt == REQ_INS_POS || rt == REQ_RM_POS || rt == REQ_READ)
				pos = pick_position(len);
			else
				pos = POS_W'($urandom_range(0, 255));
			put_request(rt, pos, pick_code(), pick_weight());
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		$display("Drove %0d request words (%0d directed) through fill, drain and mixed phases.",
			sent, directed);
		$display("Checked %0d reply words; %0d inserts met a full list.", checked, full_rejects);
		if (fail_count == 0 && pending == 0)
			$display("[ordered_list_store] OK");
		else
			$display("[ordered_list_store] ERROR");
		$finish;
	end

endmodule
